FILE: hw/rtl/qsf_pkg.sv
// ---------------------------------------------------------------------------
// qsf_pkg: shared types for the quadratic spline flattener
// Beat layouts of both channels, the segment record passed from the front
// end to the back end, and queue status.
// ---------------------------------------------------------------------------
package qsf_pkg;

    localparam int COORD_W = 24;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = t_coord'(24'sh7FFFFF);

    // input beat: one control point
    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   first_point;
        logic   last_point;
    } t_point_in;

    // output beat: one flattened point
    typedef struct packed {
        t_coord curve_x;
        t_coord curve_y;
        logic   segment_end;
        logic   outline_end;
    } t_point_out;

    // one quadratic segment: start, control, end
    typedef struct packed {
        t_coord p0_x;
        t_coord p0_y;
        t_coord p1_x;
        t_coord p1_y;
        t_coord p2_x;
        t_coord p2_y;
        logic   final_seg;
    } t_seg;

    // segment queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

FILE: hw/rtl/qsf_front.sv
// ---------------------------------------------------------------------------
// qsf_front: point classifier
// Tracks start point, pending control point and outline state, and turns
// segment-closing points into segment records for the queue.
// ---------------------------------------------------------------------------
module qsf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qsf_pkg::t_point_in  i_point,
    input  logic                i_point_valid,
    output logic                o_point_stall,
    input  qsf_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_push,
    output qsf_pkg::t_seg       o_seg
);
    import qsf_pkg::*;

    t_coord r_start_x, n_start_x;
    t_coord r_start_y, n_start_y;
    t_coord r_ctrl_x, n_ctrl_x;
    t_coord r_ctrl_y, n_ctrl_y;
    logic   r_ctrl_valid, n_ctrl_valid;
    logic   r_open, n_open;

    logic                     accept;
    logic signed [COORD_W:0]  sum_x, sum_y;
    t_coord                   mid_x, mid_y;

    // hold off only when the queue cannot take a segment
    assign o_point_stall = i_fifo_stat.full;
    assign accept        = i_point_valid && !i_fifo_stat.full;

    // midpoint of pending control and new point, rounded down
    assign sum_x = (COORD_W+1)'(i_point.point_x) + (COORD_W+1)'(r_ctrl_x);
    assign sum_y = (COORD_W+1)'(i_point.point_y) + (COORD_W+1)'(r_ctrl_y);
    assign mid_x = sum_x[COORD_W:1];
    assign mid_y = sum_y[COORD_W:1];

    // classify the beat
    always_comb begin
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        n_ctrl_x     = r_ctrl_x;
        n_ctrl_y     = r_ctrl_y;
        n_ctrl_valid = r_ctrl_valid;
        n_open       = r_open;
        o_push       = 1'b0;
        o_seg.p0_x      = r_start_x;
        o_seg.p0_y      = r_start_y;
        o_seg.p1_x      = r_ctrl_x;
        o_seg.p1_y      = r_ctrl_y;
        o_seg.p2_x      = mid_x;
        o_seg.p2_y      = mid_y;
        o_seg.final_seg = 1'b0;
        if (accept) begin
            if (i_point.first_point) begin
                n_start_x    = i_point.point_x;
                n_start_y    = i_point.point_y;
                n_ctrl_valid = 1'b0;
                n_open       = !i_point.last_point;
            end else if (r_open) begin
                if (i_point.last_point) begin
                    // final segment; straight when nothing is pending
                    if (!r_ctrl_valid) begin
                        o_seg.p1_x = i_point.point_x;
                        o_seg.p1_y = i_point.point_y;
                    end
                    o_seg.p2_x      = i_point.point_x;
                    o_seg.p2_y      = i_point.point_y;
                    o_seg.final_seg = 1'b1;
                    o_push          = 1'b1;
                    n_start_x       = i_point.point_x;
                    n_start_y       = i_point.point_y;
                    n_ctrl_valid    = 1'b0;
                    n_open          = 1'b0;
                end else if (!r_ctrl_valid) begin
                    n_ctrl_x     = i_point.point_x;
                    n_ctrl_y     = i_point.point_y;
                    n_ctrl_valid = 1'b1;
                end else begin
                    o_push    = 1'b1;
                    n_start_x = mid_x;
                    n_start_y = mid_y;
                    n_ctrl_x  = i_point.point_x;
                    n_ctrl_y  = i_point.point_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_ctrl_x     <= '0;
            r_ctrl_y     <= '0;
            r_ctrl_valid <= 1'b0;
            r_open       <= 1'b0;
        end else begin
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
            r_ctrl_x     <= n_ctrl_x;
            r_ctrl_y     <= n_ctrl_y;
            r_ctrl_valid <= n_ctrl_valid;
            r_open       <= n_open;
        end
    end

endmodule

FILE: hw/rtl/qsf_seg_fifo.sv
// ---------------------------------------------------------------------------
// qsf_seg_fifo: two-entry segment queue
// Decouples the classifier from the flattening back end.
// ---------------------------------------------------------------------------
module qsf_seg_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  qsf_pkg::t_seg       i_seg,
    input  logic                i_pop,
    output qsf_pkg::t_seg       o_seg,
    output qsf_pkg::t_fifo_stat o_stat
);
    import qsf_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    t_seg                 r_mem [DEPTH];
    logic [AW-1:0]        r_wr_ptr;
    logic [AW-1:0]        r_rd_ptr;
    logic [$clog2(DEPTH+1)-1:0] r_count;

    assign o_seg        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == ($clog2(DEPTH+1))'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_seg;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/qsf_back.sv
// ---------------------------------------------------------------------------
// qsf_back: segment flattener
// Walks each segment with second-order forward differences, then divides
// by S^2 with rounding in a reciprocal-multiply pipeline.
// ---------------------------------------------------------------------------
module qsf_back #(
    parameter int SUBDIVISIONS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qsf_pkg::t_seg       i_fifo_seg,
    input  qsf_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_pop,
    output qsf_pkg::t_point_out o_curve,
    output logic                o_curve_valid,
    input  logic                i_curve_stall
);
    import qsf_pkg::*;

    localparam int S   = SUBDIVISIONS;
    localparam int D   = S * S;
    localparam int NW  = COORD_W + 1 + $clog2(D);
    localparam int SH  = $clog2(D + 1) - 1;
    localparam int BPW = NW - SH;
    localparam int MW  = BPW + 1;
    localparam int KW  = $clog2(S + 1);
    localparam logic [63:0] RECIP = (64'd1 << NW) / 64'(D);
    localparam logic [63:0] BIAS  = (64'd1 << (COORD_W - 1)) * 64'(D) + 64'(D / 2);

    typedef struct packed {
        logic signed [NW-1:0] acc;
        logic signed [NW-1:0] d1;
        logic signed [NW-1:0] d2;
    } t_diff;

    // num(k) = D*p0 + 2kS(p1-p0) + k^2(p0-2p1+p2); state at k = 1
    function automatic t_diff diff_init(input t_coord p0, input t_coord p1,
                                        input t_coord p2);
        logic signed [NW-1:0] a;
        logic signed [NW-1:0] b;
        logic signed [NW-1:0] d1_0;
        t_diff f;
        a     = NW'(p0) - (NW'(p1) <<< 1) + NW'(p2);
        b     = NW'(p1) - NW'(p0);
        d1_0  = NW'(b * NW'(2 * S)) + a;
        f.d2  = a <<< 1;
        f.acc = NW'(NW'(p0) * NW'(D)) + d1_0;
        f.d1  = d1_0 + f.d2;
        return f;
    endfunction

    // final quotient to coordinate: remove offset, clamp high side
    function automatic t_coord to_coord(input logic [MW-1:0] q);
        t_coord c;
        if (|q[MW-1:COORD_W]) begin
            c = COORD_MAX;
        end else begin
            c = t_coord'({~q[COORD_W-1], q[COORD_W-2:0]});
        end
        return c;
    endfunction

    logic adv;
    logic gen_fire;
    logic gen_done;
    t_diff init_x, init_y;

    // generator
    logic                 r_active;
    logic [KW-1:0]        r_k;
    logic                 r_final;
    logic signed [NW-1:0] r_acc_x, r_d1_x, r_d2_x;
    logic signed [NW-1:0] r_acc_y, r_d1_y, r_d2_y;

    // divide pipeline
    logic                  r_p1_valid, r_p1_seg_end, r_p1_final;
    logic [NW-1:0]         r_p1_bx, r_p1_by;
    logic                  r_p2_valid, r_p2_seg_end, r_p2_final;
    logic [NW-1:0]         r_p2_bx, r_p2_by;
    logic [BPW+MW-1:0]     r_p2_prod_x, r_p2_prod_y;
    logic                  r_p3_valid, r_p3_seg_end, r_p3_final;
    logic [MW-1:0]         r_p3_qx, r_p3_qy;
    logic [NW-1:0]         r_p3_rx, r_p3_ry;
    logic                  r_out_valid;
    t_point_out            r_out;

    logic [NW-1:0]         b_x, b_y;
    logic [BPW+MW-1:0]     prod_x, prod_y;
    logic [MW-1:0]         qe_x, qe_y;
    logic [NW-1:0]         rem_x, rem_y;
    logic [MW-1:0]         q_x, q_y;

    // whole pipeline moves when the output register is free or taken
    assign adv      = !r_out_valid || !i_curve_stall;
    assign gen_fire = r_active && adv;
    assign gen_done = gen_fire && (r_k == KW'(S));
    assign o_pop    = !i_fifo_stat.empty && (!r_active || gen_done);

    assign init_x = diff_init(i_fifo_seg.p0_x, i_fifo_seg.p1_x, i_fifo_seg.p2_x);
    assign init_y = diff_init(i_fifo_seg.p0_y, i_fifo_seg.p1_y, i_fifo_seg.p2_y);

    // generator control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_k      <= KW'(1);
        end else if (gen_done) begin
            r_active <= 1'b0;
        end else if (gen_fire) begin
            r_k <= r_k + 1'b1;
        end
    end

    // forward-difference accumulators
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_final <= i_fifo_seg.final_seg;
            r_acc_x <= init_x.acc;
            r_d1_x  <= init_x.d1;
            r_d2_x  <= init_x.d2;
            r_acc_y <= init_y.acc;
            r_d1_y  <= init_y.d1;
            r_d2_y  <= init_y.d2;
        end else if (gen_fire) begin
            r_acc_x <= r_acc_x + r_d1_x;
            r_d1_x  <= r_d1_x + r_d2_x;
            r_acc_y <= r_acc_y + r_d1_y;
            r_d1_y  <= r_d1_y + r_d2_y;
        end
    end

    // offset to unsigned and add half divisor for rounding
    assign b_x = r_acc_x + BIAS[NW-1:0];
    assign b_y = r_acc_y + BIAS[NW-1:0];

    // reciprocal estimate, at most two below the true quotient
    assign prod_x = r_p1_bx[NW-1:SH] * RECIP[MW-1:0];
    assign prod_y = r_p1_by[NW-1:SH] * RECIP[MW-1:0];
    assign qe_x   = r_p2_prod_x[BPW+MW-1:BPW];
    assign qe_y   = r_p2_prod_y[BPW+MW-1:BPW];
    assign rem_x  = r_p2_bx - (NW'(qe_x) * NW'(D));
    assign rem_y  = r_p2_by - (NW'(qe_y) * NW'(D));

    // correction from the remainder
    assign q_x = r_p3_qx + MW'(r_p3_rx >= NW'(D)) + MW'(r_p3_rx >= NW'(2 * D));
    assign q_y = r_p3_qy + MW'(r_p3_ry >= NW'(D)) + MW'(r_p3_ry >= NW'(2 * D));

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid  <= r_active;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_out_valid <= r_p3_valid;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_bx      <= b_x;
            r_p1_by      <= b_y;
            r_p1_seg_end <= (r_k == KW'(S));
            r_p1_final   <= r_final;
            r_p2_bx      <= r_p1_bx;
            r_p2_by      <= r_p1_by;
            r_p2_prod_x  <= prod_x;
            r_p2_prod_y  <= prod_y;
            r_p2_seg_end <= r_p1_seg_end;
            r_p2_final   <= r_p1_final;
            r_p3_qx      <= qe_x;
            r_p3_qy      <= qe_y;
            r_p3_rx      <= rem_x;
            r_p3_ry      <= rem_y;
            r_p3_seg_end <= r_p2_seg_end;
            r_p3_final   <= r_p2_final;
            r_out.curve_x     <= to_coord(q_x);
            r_out.curve_y     <= to_coord(q_y);
            r_out.segment_end <= r_p3_seg_end;
            r_out.outline_end <= r_p3_seg_end && r_p3_final;
        end
    end

    assign o_curve       = r_out;
    assign o_curve_valid = r_out_valid;

endmodule

FILE: hw/rtl/quadratic_spline_flattener.sv
// ---------------------------------------------------------------------------
// quadratic_spline_flattener: quadratic outline flattening, Q12.12
// Path: segment queue, generator, p1, p2, p3, output register. Throughput:
// one output point per cycle unless the output stalls; the forward-difference
// generator's SUBDIVISIONS points per segment set the input rate.
// Reset (synchronous): outline closed, start/control zero, queue and
// pipeline empty; no clearing pass.
// ---------------------------------------------------------------------------
module quadratic_spline_flattener #(
    parameter int SUBDIVISIONS = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qsf_pkg::t_point_in  i_point,
    input  logic                i_point_valid,
    output logic                o_point_stall,
    output qsf_pkg::t_point_out o_curve,
    output logic                o_curve_valid,
    input  logic                i_curve_stall
);
    import qsf_pkg::*;

    logic       push;
    logic       pop;
    t_seg       seg_in;
    t_seg       seg_head;
    t_fifo_stat fifo_stat;

    // classifier
    qsf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point       (i_point),
        .i_point_valid (i_point_valid),
        .o_point_stall (o_point_stall),
        .i_fifo_stat   (fifo_stat),
        .o_push        (push),
        .o_seg         (seg_in)
    );

    // segment queue
    qsf_seg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (seg_in),
        .i_pop   (pop),
        .o_seg   (seg_head),
        .o_stat  (fifo_stat)
    );

    // flattener
    qsf_back #(
        .SUBDIVISIONS (SUBDIVISIONS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_seg    (seg_head),
        .i_fifo_stat   (fifo_stat),
        .o_pop         (pop),
        .o_curve       (o_curve),
        .o_curve_valid (o_curve_valid),
        .i_curve_stall (i_curve_stall)
    );

    // outline end only on a segment's last point
    a_outline_end_on_seg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_curve_valid && o_curve.outline_end |-> o_curve.segment_end)
        else $error("outline_end without segment_end");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_curve_valid)
        else $error("output valid after reset");

    // queue status is consistent
    a_fifo_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("segment queue both full and empty");

    // no segment pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.full |-> !push)
        else $error("push into full segment queue");

endmodule
